// ===== src/mcid_pkg.sv =====
// Package: shared constants for the multi-channel input debouncer.
package mcid_pkg;

   localparam int CHANNELS_DEFAULT  = 8;
   localparam int TIME_BITS_DEFAULT = 32;

   localparam int RAW_BITS    = 8;
   localparam int NOW_BITS    = 32;
   localparam int QCH_BITS    = 3;
   localparam int DEB_BITS    = 16;
   localparam int ACT_BITS    = 4;
   localparam int MASK_BITS   = 8;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam int REQ_DATA_BITS = 40;
   localparam int REQ_USER_BITS = 4;
   localparam int RSP_DATA_BITS = 56;
   localparam int RSP_USER_BITS = 1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DEBOUNCE_TIME = 2'd0,
      CSR_ACTIVE_CHANS  = 2'd1,
      CSR_ENABLE_MASK   = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   localparam logic [DEB_BITS-1:0]  DEBOUNCE_RESET = 16'd50;
   localparam logic [ACT_BITS-1:0]  ACTIVE_RESET   = 4'd8;
   localparam logic [MASK_BITS-1:0] ENABLE_RESET   = 8'hFF;

endpackage

// ===== src/multi_channel_input_debouncer.sv =====
// Top level: timestamped multi-channel input debouncer with pending-change query.
//
//  channel | direction | tdata (low bit up)                      | tuser
//  req_    | in        | raw_levels[7:0], now_ms[39:8]           | query_enable[0], query_channel[3:1]
//  rsp_    | out       | stable_levels[7:0], accepted_mask[15:8],| query_hit[0]
//          |           | query_level[16], query_time_ms[48:17]   |
//  csr_    | in        | write enable, index, 16-bit data        | -
//
// One request per cycle when not stalled; each response is captured in the output register.
// The per-channel subtract and compare plus the query mux sit between state and output register.
// Requests are taken while the output register is empty or being drained; a stalled
// response holds the input back for as long as rsp_tready stays low.
// Synchronous reset restores the register defaults and the pull-up idle levels.
module multi_channel_input_debouncer #(
   parameter int CHANNELS  = mcid_pkg::CHANNELS_DEFAULT,
   parameter int TIME_BITS = mcid_pkg::TIME_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // raw_levels, now_ms
   input  logic [mcid_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // query_enable, query_channel
   input  logic [mcid_pkg::REQ_USER_BITS-1:0] req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // stable_levels, accepted_mask, query_level, query_time_ms, zero fill
   output logic [mcid_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // query_hit
   output logic [mcid_pkg::RSP_USER_BITS-1:0] rsp_tuser,
   input  logic                               csr_we,
   input  logic [mcid_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [mcid_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int EXT = (CHANNELS > mcid_pkg::RAW_BITS) ? CHANNELS : mcid_pkg::RAW_BITS;

   logic [mcid_pkg::DEB_BITS-1:0]  debounce_ff;
   logic [mcid_pkg::ACT_BITS-1:0]  active_ff;
   logic [mcid_pkg::MASK_BITS-1:0] enable_ff;

   logic [CHANNELS-1:0]  raw_seen_ff, raw_seen_in;
   logic [CHANNELS-1:0]  stable_ff, stable_in;
   logic [CHANNELS-1:0]  pending_ff, pending_in;
   logic [CHANNELS-1:0]  level_ff, level_in;
   logic [TIME_BITS-1:0] edge_time_ff [CHANNELS];
   logic [TIME_BITS-1:0] edge_time_in [CHANNELS];
   logic [TIME_BITS-1:0] change_time_ff [CHANNELS];
   logic [TIME_BITS-1:0] change_time_in [CHANNELS];

   logic                               rsp_valid_ff;
   logic [mcid_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [mcid_pkg::RSP_USER_BITS-1:0] rsp_user_ff, rsp_user_in;

   logic [mcid_pkg::RAW_BITS-1:0] raw;
   logic [mcid_pkg::NOW_BITS-1:0] now_port;
   logic [TIME_BITS-1:0]          now;
   logic                          qen;
   logic [mcid_pkg::QCH_BITS-1:0] qch;
   logic [EXT-1:0]                raw_ext, mask_ext, stable_ext, accepted_ext;
   logic                          hit, qlevel;
   logic [TIME_BITS-1:0]          qtime;
   logic                          accept;

   assign raw      = req_tdata[mcid_pkg::RAW_BITS-1:0];
   assign now_port = req_tdata[mcid_pkg::RAW_BITS +: mcid_pkg::NOW_BITS];
   assign now      = TIME_BITS'(now_port);
   assign qen      = req_tuser[0];
   assign qch      = req_tuser[mcid_pkg::QCH_BITS:1];
   assign raw_ext  = EXT'(raw);
   assign mask_ext = EXT'(enable_ff);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      logic [TIME_BITS-1:0] diff;
      logic                 live;
      raw_seen_in  = raw_seen_ff;
      stable_in    = stable_ff;
      pending_in   = pending_ff;
      level_in     = level_ff;
      accepted_ext = '0;
      stable_ext   = '0;
      hit          = 1'b0;
      qlevel       = 1'b0;
      qtime        = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         edge_time_in[i]   = edge_time_ff[i];
         change_time_in[i] = change_time_ff[i];
         live = (i < mcid_pkg::RAW_BITS) && (32'(i) < 32'(active_ff)) && mask_ext[i];
         if (live && (raw_ext[i] != raw_seen_ff[i])) begin
            raw_seen_in[i]  = raw_ext[i];
            edge_time_in[i] = now;
         end
         diff = now - edge_time_in[i];
         if (live && (stable_ff[i] != raw_seen_in[i]) &&
             (diff >= TIME_BITS'(debounce_ff))) begin
            stable_in[i]      = raw_seen_in[i];
            pending_in[i]     = 1'b1;
            level_in[i]       = raw_seen_in[i];
            change_time_in[i] = now;
            accepted_ext[i]   = 1'b1;
         end
         stable_ext[i] = stable_in[i];
      end
      // query sees this poll's updates, then clears the pending flag
      for (int i = 0; i < CHANNELS; i++) begin
         if (qen && (32'(qch) == 32'(i)) && (32'(qch) < 32'(active_ff)) && pending_in[i]) begin
            hit           = 1'b1;
            qlevel        = level_in[i];
            qtime         = change_time_in[i];
            pending_in[i] = 1'b0;
         end
      end
      rsp_data_in = {7'd0, mcid_pkg::NOW_BITS'(qtime), qlevel,
                     accepted_ext[mcid_pkg::RAW_BITS-1:0], stable_ext[mcid_pkg::RAW_BITS-1:0]};
      rsp_user_in = hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= mcid_pkg::DEBOUNCE_RESET;
         active_ff   <= mcid_pkg::ACTIVE_RESET;
         enable_ff   <= mcid_pkg::ENABLE_RESET;
      end else if (csr_we) begin
         unique case (mcid_pkg::csr_index_type'(csr_index))
            mcid_pkg::CSR_DEBOUNCE_TIME: debounce_ff <= csr_wdata;
            mcid_pkg::CSR_ACTIVE_CHANS:  active_ff   <= csr_wdata[mcid_pkg::ACT_BITS-1:0];
            mcid_pkg::CSR_ENABLE_MASK:   enable_ff   <= csr_wdata[mcid_pkg::MASK_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_seen_ff <= '1;
         stable_ff   <= '1;
         pending_ff  <= '0;
         level_ff    <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            edge_time_ff[i]   <= '0;
            change_time_ff[i] <= '0;
         end
      end else if (accept) begin
         raw_seen_ff <= raw_seen_in;
         stable_ff   <= stable_in;
         pending_ff  <= pending_in;
         level_ff    <= level_in;
         for (int i = 0; i < CHANNELS; i++) begin
            edge_time_ff[i]   <= edge_time_in[i];
            change_time_ff[i] <= change_time_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
